@@ sv/nvse_pkg.sv @@
// Shared types and constants for the NMEA speed extractor.
package nvse_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int TYPE_W  = 24;
    localparam int FIELD_W = 5;
    localparam int PART_W  = 16;
    localparam int WIN_W   = 48;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 5'd31;
    localparam logic [PART_W-1:0]  PART_SAT  = 16'hFFFF;

    localparam logic [TYPE_W-1:0]  HEADER_TYPE_RST = 24'h565447;
    localparam logic [FIELD_W-1:0] FIRST_FIELD_RST   = 5'd5;
    localparam logic [FIELD_W-1:0] SECOND_FIELD_RST  = 5'd7;

    localparam int TOK_DEPTH = 4;
    localparam int TOK_PTR_W = 2;
    localparam int TOK_CNT_W = 3;

    localparam int RES_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_TYPE = 2'd0,
        CFG_FIRST_FIELD   = 2'd1,
        CFG_SECOND_FIELD  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        TOK_COMMA,
        TOK_DOT,
        TOK_DIGIT,
        TOK_END
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [3:0]  digit;
    } token_t;

    typedef struct packed {
        logic [PART_W-1:0] knots_whole;
        logic [PART_W-1:0] knots_fraction;
        logic [PART_W-1:0] kmh_whole;
        logic [PART_W-1:0] kmh_fraction;
        logic              speed_valid;
    } result_t;

endpackage

@@ sv/nvse_tok_fifo.sv @@
// Short token queue between the front and back parts.
module nvse_tok_fifo
    import nvse_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  token_t wr_token,
    output logic   full,
    input  logic   rd_en,
    output token_t rd_token,
    output logic   empty
);

    token_t                 mem_reg [TOK_DEPTH];
    logic [TOK_PTR_W-1:0]   wr_ptr_reg;
    logic [TOK_PTR_W-1:0]   wr_ptr_next;
    logic [TOK_PTR_W-1:0]   rd_ptr_reg;
    logic [TOK_PTR_W-1:0]   rd_ptr_next;
    logic [TOK_CNT_W-1:0]   count_reg;
    logic [TOK_CNT_W-1:0]   count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full     = (count_reg == TOK_CNT_W'(TOK_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_token = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_token;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= TOK_CNT_W'(TOK_DEPTH))
        else $error("Token queue count exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 3'd1))
        else $error("Token queue lost a write.");
`endif

endmodule

@@ sv/nvse_front.sv @@
// Header hunting and byte classification into parser tokens.
module nvse_front
    import nvse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        rx_byte,
    input  logic [TYPE_W-1:0] header_type,
    input  logic              tok_full,
    output logic              tok_wr,
    output token_t            tok
);

    logic [WIN_W-1:0] window_reg;
    logic [WIN_W-1:0] window_next;
    logic             in_sentence_reg;
    logic             in_sentence_next;
    logic             last_cr_reg;
    logic             last_cr_next;
    logic [WIN_W-1:0] want;
    logic [WIN_W-1:0] shifted;
    logic             accept;

    assign want    = {CH_DOLLAR, CH_G, CH_P, header_type};
    assign shifted = {window_reg[WIN_W-9:0], rx_byte};
    assign accept  = push && !tok_full;

    always_comb
    begin
        window_next      = window_reg;
        in_sentence_next = in_sentence_reg;
        last_cr_next     = last_cr_reg;
        tok_wr           = 1'b0;
        tok.kind         = TOK_DIGIT;
        tok.digit        = rx_byte[3:0];
        if (accept)
        begin
            if (!in_sentence_reg)
            begin
                window_next = shifted;
                if (shifted == want)
                begin
                    in_sentence_next = 1'b1;
                    last_cr_next     = 1'b0;
                end
            end
            else if ((rx_byte == CH_LF) && last_cr_reg)
            begin
                tok_wr           = 1'b1;
                tok.kind         = TOK_END;
                in_sentence_next = 1'b0;
                window_next      = '0;
                last_cr_next     = 1'b0;
            end
            else
            begin
                last_cr_next = (rx_byte == CH_CR);
                if (rx_byte == CH_COMMA)
                begin
                    tok_wr   = 1'b1;
                    tok.kind = TOK_COMMA;
                end
                else if (rx_byte == CH_DOT)
                begin
                    tok_wr   = 1'b1;
                    tok.kind = TOK_DOT;
                end
                else if ((rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE))
                begin
                    tok_wr   = 1'b1;
                    tok.kind = TOK_DIGIT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            in_sentence_reg <= 1'b0;
            last_cr_reg     <= 1'b0;
        end
        else
        begin
            window_reg      <= window_next;
            in_sentence_reg <= in_sentence_next;
            last_cr_reg     <= last_cr_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_sentence_reg) |-> (window_reg == want))
        else $error("Sentence started without a header match.");
`endif

endmodule

@@ sv/nvse_back.sv @@
// Speed field parser with accumulators and the result queue.
module nvse_back
    import nvse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FIELD_W-1:0] first_speed_field,
    input  logic [FIELD_W-1:0] second_speed_field,
    input  logic               tok_empty,
    input  token_t             tok,
    output logic               tok_rd,
    input  logic               pop,
    output logic               empty,
    output result_t            result
);

    logic [FIELD_W-1:0] field_count_reg;
    logic [FIELD_W-1:0] field_count_next;
    logic               after_dot_reg;
    logic               after_dot_next;
    logic [PART_W-1:0]  parts_reg [4];
    logic [PART_W-1:0]  parts_next [4];
    logic [3:0]         part_seen_reg;
    logic [3:0]         part_seen_next;
    logic               error_reg;
    logic               error_next;

    result_t            res_mem_reg [RES_DEPTH];
    logic               res_wr_ptr_reg;
    logic               res_rd_ptr_reg;
    logic [1:0]         res_count_reg;
    logic [1:0]         res_count_next;
    logic               res_full;
    logic               res_wr;
    logic               res_rd;
    result_t            res_new;

    logic               in_knots;
    logic               in_kmh;
    logic               in_field;
    logic [1:0]         idx;
    logic [19:0]        acc;
    logic               ok;

    assign res_full = (res_count_reg == 2'(RES_DEPTH));
    assign empty    = (res_count_reg == '0);
    assign res_rd   = pop && !empty;
    assign tok_rd   = !tok_empty && ((tok.kind != TOK_END) || !res_full);
    assign result   = res_mem_reg[res_rd_ptr_reg];

    assign in_knots = (field_count_reg == first_speed_field);
    assign in_kmh   = !in_knots && (field_count_reg == second_speed_field);
    assign in_field = in_knots || in_kmh;
    assign idx      = {in_kmh, after_dot_reg};
    assign acc      = {4'b0, parts_reg[idx]} * 20'd10 + {16'b0, tok.digit};
    assign ok       = !error_reg && (part_seen_reg == 4'hF);

    always_comb
    begin
        field_count_next = field_count_reg;
        after_dot_next   = after_dot_reg;
        parts_next       = parts_reg;
        part_seen_next   = part_seen_reg;
        error_next       = error_reg;
        res_wr           = 1'b0;
        res_new.knots_whole    = ok ? parts_reg[0] : '0;
        res_new.knots_fraction = ok ? parts_reg[1] : '0;
        res_new.kmh_whole      = ok ? parts_reg[2] : '0;
        res_new.kmh_fraction   = ok ? parts_reg[3] : '0;
        res_new.speed_valid    = ok;
        if (tok_rd)
        begin
            unique case (tok.kind)
                TOK_COMMA:
                begin
                    if (in_field && !after_dot_reg)
                    begin
                        error_next = 1'b1;
                    end
                    if (field_count_reg != FIELD_MAX)
                    begin
                        field_count_next = field_count_reg + 1'b1;
                    end
                    after_dot_next = 1'b0;
                end
                TOK_DOT:
                begin
                    if (in_field)
                    begin
                        if (after_dot_reg)
                        begin
                            error_next = 1'b1;
                        end
                        after_dot_next = 1'b1;
                    end
                end
                TOK_DIGIT:
                begin
                    if (in_field)
                    begin
                        parts_next[idx]     = (acc > 20'(PART_SAT)) ? PART_SAT
                                                                    : acc[PART_W-1:0];
                        part_seen_next[idx] = 1'b1;
                    end
                end
                TOK_END:
                begin
                    res_wr           = 1'b1;
                    field_count_next = '0;
                    after_dot_next   = 1'b0;
                    parts_next[0]    = '0;
                    parts_next[1]    = '0;
                    parts_next[2]    = '0;
                    parts_next[3]    = '0;
                    part_seen_next   = '0;
                    error_next       = 1'b0;
                end
                default:
                begin
                    error_next = error_reg;
                end
            endcase
        end
        res_count_next = res_count_reg;
        if (res_wr && !res_rd)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (res_rd && !res_wr)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg <= '0;
            after_dot_reg   <= 1'b0;
            parts_reg[0]    <= '0;
            parts_reg[1]    <= '0;
            parts_reg[2]    <= '0;
            parts_reg[3]    <= '0;
            part_seen_reg   <= '0;
            error_reg       <= 1'b0;
            res_wr_ptr_reg  <= 1'b0;
            res_rd_ptr_reg  <= 1'b0;
            res_count_reg   <= '0;
        end
        else
        begin
            field_count_reg <= field_count_next;
            after_dot_reg   <= after_dot_next;
            parts_reg       <= parts_next;
            part_seen_reg   <= part_seen_next;
            error_reg       <= error_next;
            res_count_reg   <= res_count_next;
            if (res_wr)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_rd)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
        begin
            res_mem_reg[res_wr_ptr_reg] <= res_new;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= 2'(RES_DEPTH))
        else $error("Result queue count exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.speed_valid) |->
            ((result.knots_whole == '0) && (result.knots_fraction == '0) &&
             (result.kmh_whole == '0) && (result.kmh_fraction == '0)))
        else $error("Invalid result carries nonzero speed values.");
`endif

endmodule

@@ sv/nmea_vtg_speed_extractor.sv @@
// Top level of the NMEA speed extractor.
//
// Input channel: a received byte is presented on rx_byte with push high; the
// transaction completes at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on the speed ports;
// the transaction completes at a clock edge where pop is high and empty is low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 header
// type, 1 knots field, 2 km/h field) at the clock edge; other indexes do nothing.
// One byte is taken every cycle while full is low. A front stage hunts for the
// header and turns bytes into tokens, a four-entry token queue decouples it
// from the parser, and the parser handles one token per cycle into a two-entry
// result queue, holding an end token while that queue is full. The closing LF's
// end token passes the token queue to the parser, whose result write makes empty
// go low. When the receiver stops popping, the result queue fills, the parser
// stalls on the next end token, the token queue fills and full rises; no data
// is lost. Reset clears all parse state, empties both queues and loads the
// default registers (VTG, fields 5 and 7).
module nmea_vtg_speed_extractor
    import nvse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           rx_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [PART_W-1:0]    knots_whole,
    output logic [PART_W-1:0]    knots_fraction,
    output logic [PART_W-1:0]    kmh_whole,
    output logic [PART_W-1:0]    kmh_fraction,
    output logic                 speed_valid
);

    logic [TYPE_W-1:0]  header_type_reg;
    logic [FIELD_W-1:0] first_field_reg;
    logic [FIELD_W-1:0] second_field_reg;

    logic    tok_wr;
    token_t  tok_in;
    logic    tok_full;
    logic    tok_rd;
    token_t  tok_out;
    logic    tok_empty;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_type_reg   <= HEADER_TYPE_RST;
            first_field_reg   <= FIRST_FIELD_RST;
            second_field_reg  <= SECOND_FIELD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_TYPE:   header_type_reg   <= cfg_data[TYPE_W-1:0];
                CFG_FIRST_FIELD:   first_field_reg   <= cfg_data[FIELD_W-1:0];
                CFG_SECOND_FIELD:  second_field_reg  <= cfg_data[FIELD_W-1:0];
                default:           first_field_reg   <= first_field_reg;
            endcase
        end
    end

    assign full = tok_full;

    nvse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .rx_byte       (rx_byte),
        .header_type   (header_type_reg),
        .tok_full      (tok_full),
        .tok_wr        (tok_wr),
        .tok           (tok_in)
    );

    nvse_tok_fifo u_tok_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tok_wr),
        .wr_token (tok_in),
        .full     (tok_full),
        .rd_en    (tok_rd),
        .rd_token (tok_out),
        .empty    (tok_empty)
    );

    nvse_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .first_speed_field  (first_field_reg),
        .second_speed_field (second_field_reg),
        .tok_empty          (tok_empty),
        .tok                (tok_out),
        .tok_rd             (tok_rd),
        .pop                (pop),
        .empty              (empty),
        .result             (result)
    );

    assign knots_whole    = result.knots_whole;
    assign knots_fraction = result.knots_fraction;
    assign kmh_whole      = result.kmh_whole;
    assign kmh_fraction   = result.kmh_fraction;
    assign speed_valid    = result.speed_valid;

endmodule

@@ bench/nmea_vtg_speed_extractor_test.sv @@
// Self-checking testbench that streams NMEA bytes into the speed extractor and checks each result.
`timescale 1ns / 100ps

module nmea_vtg_speed_extractor_test;
    import nvse_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [7:0] LETTER_LO = 8'h41;
    localparam logic [7:0] LETTER_HI = 8'h5A;
    localparam int IDLE_PCT = 29;
    localparam int SETTLE_CYCLES = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic [7:0]           rx_byte;
    logic                 empty;
    logic                 pop;
    logic [PART_W-1:0]    knots_whole;
    logic [PART_W-1:0]    knots_fraction;
    logic [PART_W-1:0]    kmh_whole;
    logic [PART_W-1:0]    kmh_fraction;
    logic                 speed_valid;

    logic steady = 1'b0;

    logic [TYPE_W-1:0]  type_reg;
    logic [FIELD_W-1:0] knots_field;
    logic [FIELD_W-1:0] kmh_field;
    logic [WIN_W-1:0]   window;
    logic               in_sent;
    logic [FIELD_W-1:0] field_cnt;
    logic               dot_seen;
    logic [PART_W-1:0]  part_acc [4];
    logic [3:0]         part_seen;
    logic               fmt_err;
    logic               cr_prev;

    result_t pending_speeds[$];

    int error_count = 0;
    int sent_bytes = 0;
    int checked_count = 0;
    int valid_count = 0;
    int setup_count = 0;

    nmea_vtg_speed_extractor u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .knots_whole    (knots_whole),
        .knots_fraction (knots_fraction),
        .kmh_whole      (kmh_whole),
        .kmh_fraction   (kmh_fraction),
        .speed_valid    (speed_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void clear_parse();
        field_cnt = '0;
        dot_seen  = 1'b0;
        part_acc  = '{default: '0};
        part_seen = '0;
        fmt_err   = 1'b0;
        cr_prev   = 1'b0;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        result_t     res;
        logic        ok;
        int          slot;
        int          idx;
        int unsigned acc;
        if (!in_sent)
        begin
            window = {window[WIN_W-9:0], b};
            if (window == {CH_DOLLAR, CH_G, CH_P, type_reg})
            begin
                in_sent = 1'b1;
                clear_parse();
            end
        end
        else if (b == CH_LF && cr_prev)
        begin
            ok = !fmt_err && part_seen == 4'hF;
            res.knots_whole    = ok ? part_acc[0] : '0;
            res.knots_fraction = ok ? part_acc[1] : '0;
            res.kmh_whole      = ok ? part_acc[2] : '0;
            res.kmh_fraction   = ok ? part_acc[3] : '0;
            res.speed_valid    = ok;
            pending_speeds.push_back(res);
            in_sent = 1'b0;
            window  = '0;
            clear_parse();
        end
        else
        begin
            cr_prev = (b == CH_CR);
            if (field_cnt == knots_field)
                slot = 0;
            else if (field_cnt == kmh_field)
                slot = 2;
            else
                slot = 4;
            if (b == CH_COMMA)
            begin
                if (slot != 4 && !dot_seen)
                    fmt_err = 1'b1;
                if (field_cnt != FIELD_MAX)
                    field_cnt = field_cnt + 1'b1;
                dot_seen = 1'b0;
            end
            else if (slot != 4)
            begin
                if (b == CH_DOT)
                begin
                    if (dot_seen)
                        fmt_err = 1'b1;
                    dot_seen = 1'b1;
                end
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    idx = slot + int'(dot_seen);
                    acc = part_acc[idx] * 10 + (b - CH_ZERO);
                    part_acc[idx] = (acc > PART_SAT) ? PART_SAT : acc[PART_W-1:0];
                    part_seen[idx] = 1'b1;
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_bytes++;
        parse_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_eol();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // Closes an open sentence, drains all results and lets the pipeline empty out.
    task automatic settle();
        if (in_sent)
            send_eol();
        push <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_HEADER_TYPE:   type_reg = data[TYPE_W-1:0];
            CFG_FIRST_FIELD:   knots_field = data[FIELD_W-1:0];
            CFG_SECOND_FIELD:  kmh_field = data[FIELD_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [FIELD_W-1:0] pick_field();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 5'd1;
        if (r == 1)
            return FIELD_MAX;
        return FIELD_W'($urandom_range(1, 6));
    endfunction

    task automatic pick_random_setup();
        logic [TYPE_W-1:0]  stype;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] second;
        case ($urandom_range(0, 9))
            0: stype = '0;
            1: stype = '1;
            2: stype = TYPE_W'($urandom);
            default: stype = {8'($urandom_range(LETTER_LO, LETTER_HI)),
                              8'($urandom_range(LETTER_LO, LETTER_HI)),
                              8'($urandom_range(LETTER_LO, LETTER_HI))};
        endcase
        first  = pick_field();
        second = ($urandom_range(0, 9) == 0) ? first : pick_field();
        write_reg(CFG_HEADER_TYPE, stype);
        write_reg(CFG_FIRST_FIELD, {(CFG_W-FIELD_W)'($urandom), first});
        write_reg(CFG_SECOND_FIELD, {(CFG_W-FIELD_W)'($urandom), second});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, CFG_W'($urandom));
        setup_count++;
    endtask

    task automatic send_digits();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
        repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_speed_text();
        int flaw;
        flaw = $urandom_range(0, 11);
        if (flaw != 3)
            send_digits();
        if (flaw == 2)
            send_byte(8'($urandom_range(0, 255)));
        if (flaw != 0)
            send_byte(CH_DOT);
        if (flaw == 1)
            send_byte(CH_DOT);
        if (flaw != 4)
            send_digits();
    endtask

    task automatic send_random_sentence();
        int last_field;
        int roll;
        last_field = (knots_field > kmh_field) ? knots_field : kmh_field;
        last_field += $urandom_range(0, 2);
        if (knots_field == FIELD_MAX || kmh_field == FIELD_MAX)
            last_field += $urandom_range(0, 3);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            send_text("$GP");
        send_byte(CH_DOLLAR);
        send_byte(CH_G);
        send_byte(CH_P);
        send_byte(type_reg[23:16]);
        send_byte(type_reg[15:8]);
        send_byte(type_reg[7:0]);
        for (int f = 0; f <= last_field; f++)
        begin
            if (f > 0)
                send_byte(CH_COMMA);
            if (f == knots_field || f == kmh_field
                    || (f >= FIELD_MAX && (knots_field == FIELD_MAX || kmh_field == FIELD_MAX)))
                send_speed_text();
            else
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(LETTER_LO, LETTER_HI)));
        end
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            send_byte(CH_CR);
            send_byte(8'($urandom_range(0, 255)));
        end
        if (roll != 1)
            send_eol();
    endtask

    task automatic test_default_vtg();
        send_text("$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K");
        send_eol();
        settle();
    endtask

    task automatic test_register_writes();
        write_reg(CFG_FIRST_FIELD, {19'h7FFFF, 5'd1});
        write_reg(CFG_SECOND_FIELD, {19'h55555, 5'd2});
        write_reg(CFG_HEADER_TYPE, 24'h414243);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        setup_count++;
        send_text("$GPVTG,1.1,2.2");
        send_eol();
        send_text("$GPABC,12.5,3.25");
        send_eol();
        settle();
    endtask

    task automatic test_speed_fields();
        send_text("$GPABC,99999999.65536,0.0");
        send_eol();
        send_text("$GPABC,12,3.4");
        send_eol();
        send_text("$GPABC,1.2.3,4.5");
        send_eol();
        send_text("$GPABC,1a.b2,3x.4");
        send_eol();
        send_text("$GPABC,1");
        send_byte(CH_LF);
        send_text(".2,3");
        send_byte(CH_CR);
        send_text("4.5");
        send_eol();
        send_text("$GPABC,.5,3.4");
        send_eol();
        send_text("$GPABC,1.2,3.");
        send_eol();
        send_text("$GPABC,1.$GPABC2,3.4");
        send_eol();
        settle();
    endtask

    task automatic test_header_hunting();
        send_byte(8'hFF);
        send_text("$GPABD,1.1,1.1");
        send_eol();
        send_text("$GP$GPABC,7.7,8.8");
        send_eol();
        send_text("$GPAB$GPABC,7.25,0.5");
        send_eol();
        settle();
    endtask

    task automatic test_same_field();
        write_reg(CFG_SECOND_FIELD, 24'd1);
        setup_count++;
        send_text("$GPABC,5.5,6.6");
        send_eol();
        settle();
    endtask

    task automatic test_many_fields();
        write_reg(CFG_SECOND_FIELD, {19'd0, FIELD_MAX});
        setup_count++;
        send_text("$GPABC,1.5");
        for (int i = 2; i <= 34; i++)
        begin
            send_byte(CH_COMMA);
            if (i >= FIELD_MAX)
                send_text("1.2");
        end
        send_eol();
        settle();
    endtask

    task automatic test_random_sentences();
        int start;
        start = sent_bytes;
        while (sent_bytes - start < 500)
        begin
            settle();
            pick_random_setup();
            repeat (5)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(4, 16)) send_byte(8'($urandom_range(0, 255)));
                send_random_sentence();
            end
        end
        settle();
    endtask

    task automatic test_back_to_back();
        pick_random_setup();
        steady = 1'b1;
        repeat (4) send_random_sentence();
        settle();
        steady = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [PART_W-1:0] exp_v,
                               input logic [PART_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    initial
    begin
        result_t exp_res;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                checked_count++;
                if (pending_speeds.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected transaction, expected none actual %h",
                             $time, {knots_whole, knots_fraction, kmh_whole, kmh_fraction,
                                     speed_valid});
                end
                else
                begin
                    exp_res = pending_speeds.pop_front();
                    check_field("knots_whole", exp_res.knots_whole, knots_whole);
                    check_field("knots_fraction", exp_res.knots_fraction, knots_fraction);
                    check_field("kmh_whole", exp_res.kmh_whole, kmh_whole);
                    check_field("kmh_fraction", exp_res.kmh_fraction, kmh_fraction);
                    check_field("speed_valid", exp_res.speed_valid, speed_valid);
                    if (exp_res.speed_valid)
                        valid_count++;
                end
            end
            pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        rx_byte   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        type_reg    = HEADER_TYPE_RST;
        knots_field = FIRST_FIELD_RST;
        kmh_field   = SECOND_FIELD_RST;
        window      = '0;
        in_sent     = 1'b0;
        clear_parse();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_default_vtg();
        test_register_writes();
        test_speed_fields();
        test_header_hunting();
        test_same_field();
        test_many_fields();
        test_random_sentences();
        test_back_to_back();
        settle();

        $display("Streamed %0d bytes under %0d register setups.", sent_bytes, setup_count + 1);
        $display("Checked %0d sentence results, %0d of them valid.", checked_count, valid_count);
        if (error_count == 0 && pending_speeds.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
